// ===== hw/rtl/fpr_pkg.sv =====
package fpr_pkg;

   localparam int BYTE_W = 8;
   localparam int ID_W   = 16;
   localparam int LEN_W  = 7;   // payload length, 0..64
   localparam int IDX_W  = 6;   // byte_index port width
   localparam int OP_W   = 2;
   localparam int CSR_W  = 1;

   // request operations
   localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
   localparam logic [OP_W-1:0] OP_TAKE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // configuration register indexes
   localparam logic [CSR_W-1:0] CSR_START_SYMBOL = 1'b0;
   localparam logic [CSR_W-1:0] CSR_HDR_BYTES    = 1'b1;

   localparam logic [BYTE_W-1:0] START_SYMBOL_RST = 8'd126;
   localparam logic [BYTE_W-1:0] HDR_BYTES_RST    = 8'd7;

   // command from the request side to the deframer
   typedef struct packed {
      logic              byte_en;
      logic              rearm;
      logic [BYTE_W-1:0] data_byte;
   } frm_cmd_type;

   // deframer status
   typedef struct packed {
      logic done;       // packet complete now
      logic done_next;  // packet complete after this cycle's command
      logic error;      // this cycle's length byte is bad
   } frm_status_type;

   // captured header
   typedef struct packed {
      logic [BYTE_W-1:0] destination;
      logic [BYTE_W-1:0] source;
      logic [ID_W-1:0]   packet_id;
      logic [BYTE_W-1:0] service;
      logic [BYTE_W-1:0] crc_byte;
      logic [LEN_W-1:0]  length;
   } hdr_type;

endpackage

// ===== hw/rtl/fpr_payload_ram.sv =====
module fpr_payload_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [fpr_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [fpr_pkg::BYTE_W-1:0] rd_data
);

   logic [fpr_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [fpr_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fpr_deframer.sv =====
module fpr_deframer #(
   parameter int MAX_PAYLOAD = 64,
   parameter int ADDR_W      = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fpr_pkg::frm_cmd_type       cmd,
   input  logic [fpr_pkg::BYTE_W-1:0] start_symbol,
   input  logic [fpr_pkg::BYTE_W-1:0] hdr_bytes,
   output fpr_pkg::frm_status_type    status,
   output fpr_pkg::hdr_type           hdr,
   output logic                       wr_en,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic [fpr_pkg::BYTE_W-1:0] wr_data
);

   localparam logic [3:0] PH_WAIT = 4'd0;
   localparam logic [3:0] PH_DEST = 4'd1;
   localparam logic [3:0] PH_SRC  = 4'd2;
   localparam logic [3:0] PH_LEN  = 4'd3;
   localparam logic [3:0] PH_IDHI = 4'd4;
   localparam logic [3:0] PH_IDLO = 4'd5;
   localparam logic [3:0] PH_SERV = 4'd6;
   localparam logic [3:0] PH_CRC  = 4'd7;
   localparam logic [3:0] PH_PAY  = 4'd8;
   localparam logic [3:0] PH_DONE = 4'd9;

   localparam logic [fpr_pkg::BYTE_W-1:0] MAX_PAY_B = fpr_pkg::BYTE_W'(MAX_PAYLOAD);

   logic [3:0]                  phase_ff, phase_in;
   fpr_pkg::hdr_type            hdr_ff, hdr_in;
   logic [fpr_pkg::LEN_W-1:0]   fill_ff, fill_in;
   logic [fpr_pkg::LEN_W-1:0]   fill_plus;
   logic [fpr_pkg::BYTE_W:0]    diff;
   logic                        bad_len;
   logic                        err;

   always_comb begin
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      fill_in   = fill_ff;
      err       = 1'b0;
      wr_en     = 1'b0;
      fill_plus = fill_ff + fpr_pkg::LEN_W'(1);
      diff      = {1'b0, cmd.data_byte} - {1'b0, hdr_bytes};
      bad_len   = diff[fpr_pkg::BYTE_W] || (diff[fpr_pkg::BYTE_W-1:0] > MAX_PAY_B);

      if (cmd.rearm) begin
         phase_in      = PH_WAIT;
         fill_in       = '0;
         hdr_in.length = '0;
      end else if (cmd.byte_en) begin
         case (phase_ff)
            PH_WAIT: begin
               if (cmd.data_byte == start_symbol) begin
                  phase_in = PH_DEST;
               end
            end
            PH_DEST: begin
               hdr_in.destination = cmd.data_byte;
               phase_in = PH_SRC;
            end
            PH_SRC: begin
               hdr_in.source = cmd.data_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (bad_len) begin
                  err           = 1'b1;
                  phase_in      = PH_WAIT;
                  fill_in       = '0;
                  hdr_in.length = '0;
               end else begin
                  hdr_in.length = diff[fpr_pkg::LEN_W-1:0];
                  fill_in       = '0;
                  phase_in      = PH_IDHI;
               end
            end
            PH_IDHI: begin
               hdr_in.packet_id = {cmd.data_byte, fpr_pkg::BYTE_W'(0)};
               phase_in = PH_IDLO;
            end
            PH_IDLO: begin
               hdr_in.packet_id[fpr_pkg::BYTE_W-1:0] = cmd.data_byte;
               phase_in = PH_SERV;
            end
            PH_SERV: begin
               hdr_in.service = cmd.data_byte;
               phase_in = PH_CRC;
            end
            PH_CRC: begin
               hdr_in.crc_byte = cmd.data_byte;
               phase_in = (hdr_ff.length == '0) ? PH_DONE : PH_PAY;
            end
            PH_PAY: begin
               wr_en   = 1'b1;
               fill_in = fill_plus;
               if (fill_plus >= hdr_ff.length) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in      = PH_WAIT;
               fill_in       = '0;
               hdr_in.length = '0;
            end
         endcase
      end
   end

   assign wr_addr = fill_ff[ADDR_W-1:0];
   assign wr_data = cmd.data_byte;

   assign status.done      = (phase_ff == PH_DONE);
   assign status.done_next = (phase_in == PH_DONE);
   assign status.error     = err;
   assign hdr              = hdr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         hdr_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

// ===== hw/rtl/framed_packet_receiver.sv =====
// Start-symbol framed packet receiver.
// Request channel (req_valid/req_stall): req_operation selects a line byte
// (req_data_byte), a take of the finished packet, or a clear. Result channel
// (rsp_valid/rsp_stall) carries one registered result per request, or for a
// take of a finished packet one result per payload byte (one for an empty
// payload), rsp_last on the final one.
// Config port (csr_valid/csr_ready, csr_index, csr_data): index 0 start
// symbol, index 1 header size. csr_ready is always high; write only when idle.
// A result is registered in the cycle after its request is accepted; the
// first result of a non-empty take passes the payload RAM read register
// and then the output register. Byte, clear and non-taking requests go one
// per cycle while the output is not stalled. A take of an N-byte payload
// emits N results one per cycle while rsp_stall is low, paced by the payload
// RAM read port (one read per cycle); requests stall until the last result is loaded.
// Reset: receiver waits for the start symbol, header fields zero, registers
// at 126 and 7. Payload RAM is not cleared; only written entries are read.
// When rsp_stall is high the held result stays and no request is taken
// until the output register frees up.
module framed_packet_receiver #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [fpr_pkg::OP_W-1:0]    req_operation,
   input  logic [fpr_pkg::BYTE_W-1:0]  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_finished,
   output logic                        rsp_packet_valid,
   output logic                        rsp_error,
   output logic [fpr_pkg::BYTE_W-1:0]  rsp_destination,
   output logic [fpr_pkg::BYTE_W-1:0]  rsp_source,
   output logic [fpr_pkg::ID_W-1:0]    rsp_packet_id,
   output logic [fpr_pkg::BYTE_W-1:0]  rsp_service,
   output logic [fpr_pkg::BYTE_W-1:0]  rsp_crc_byte,
   output logic [fpr_pkg::LEN_W-1:0]   rsp_payload_length,
   output logic [fpr_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic [fpr_pkg::IDX_W-1:0]   rsp_byte_index,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fpr_pkg::CSR_W-1:0]   csr_index,
   input  logic [fpr_pkg::BYTE_W-1:0]  csr_data
);

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // take sequencer
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                         state_ff, state_in;
   logic [ADDR_W-1:0]            idx_ff, idx_in;
   logic [fpr_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [fpr_pkg::LEN_W-1:0]    idx_plus;

   // config registers
   logic [fpr_pkg::BYTE_W-1:0]   start_symbol_ff, start_symbol_in;
   logic [fpr_pkg::BYTE_W-1:0]   hdr_bytes_ff, hdr_bytes_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         load;
   logic                         finished_ff, finished_in;
   logic                         packet_valid_ff, packet_valid_in;
   logic                         error_ff, error_in;
   fpr_pkg::hdr_type             out_hdr_ff, out_hdr_in;
   logic [fpr_pkg::BYTE_W-1:0]   payload_byte_ff, payload_byte_in;
   logic [fpr_pkg::IDX_W-1:0]    byte_index_ff, byte_index_in;
   logic                         last_ff, last_in;

   logic                         out_free;
   logic                         req_accept;
   logic                         take_go;
   fpr_pkg::frm_cmd_type         cmd;
   fpr_pkg::frm_status_type      status;
   fpr_pkg::hdr_type             hdr;
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [fpr_pkg::BYTE_W-1:0]   wr_data;
   logic                         rd_en;
   logic [ADDR_W-1:0]            rd_addr;
   logic [fpr_pkg::BYTE_W-1:0]   rd_data;

   // register file: always ready, writes land in the next cycle
   assign csr_ready = 1'b1;

   always_comb begin
      start_symbol_in = start_symbol_ff;
      hdr_bytes_in    = hdr_bytes_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            fpr_pkg::CSR_START_SYMBOL: start_symbol_in = csr_data;
            fpr_pkg::CSR_HDR_BYTES:    hdr_bytes_in    = csr_data;
            default: begin
               start_symbol_in = start_symbol_ff;
            end
         endcase
      end
   end

   // request side
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign take_go    = req_accept && (req_operation == fpr_pkg::OP_TAKE) && status.done;

   // a clear, or a take of a finished packet, rearms the receiver
   assign cmd.byte_en   = req_accept && (req_operation == fpr_pkg::OP_BYTE);
   assign cmd.rearm     = (req_accept && (req_operation == fpr_pkg::OP_CLEAR)) || take_go;
   assign cmd.data_byte = req_data_byte;

   fpr_deframer #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .ADDR_W      (ADDR_W)
   ) u_deframer (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .start_symbol (start_symbol_ff),
      .hdr_bytes    (hdr_bytes_ff),
      .status       (status),
      .hdr          (hdr),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   fpr_payload_ram #(
      .DEPTH  (MAX_PAYLOAD),
      .ADDR_W (ADDR_W)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result building. A take of a non-empty payload reads entry 0 at accept,
   // then each loaded result issues the read for the next entry, so the RAM
   // data is ready in the next cycle. The header regs stay put during the run
   // (requests are stalled); only the length is cleared by the rearm, so it
   // is latched here.
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      len_in          = len_ff;
      rd_en           = 1'b0;
      idx_plus        = fpr_pkg::LEN_W'(idx_ff) + fpr_pkg::LEN_W'(1);
      rd_addr         = idx_plus[ADDR_W-1:0];
      load            = 1'b0;
      finished_in     = finished_ff;
      packet_valid_in = packet_valid_ff;
      error_in        = error_ff;
      out_hdr_in      = out_hdr_ff;
      payload_byte_in = payload_byte_ff;
      byte_index_in   = byte_index_ff;
      last_in         = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               load            = 1'b1;
               finished_in     = status.done_next;
               packet_valid_in = 1'b0;
               error_in        = status.error;
               out_hdr_in      = '0;
               payload_byte_in = '0;
               byte_index_in   = '0;
               last_in         = 1'b1;
               if (take_go) begin
                  // empty payload: the single result goes out now
                  packet_valid_in = 1'b1;
                  out_hdr_in      = hdr;
                  if (hdr.length != '0) begin
                     load     = 1'b0;
                     len_in   = hdr.length;
                     idx_in   = '0;
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load              = 1'b1;
               finished_in       = status.done;
               packet_valid_in   = 1'b1;
               error_in          = 1'b0;
               out_hdr_in        = hdr;
               out_hdr_in.length = len_ff;
               payload_byte_in   = rd_data;
               byte_index_in     = fpr_pkg::IDX_W'(idx_ff);
               last_in           = (idx_plus == len_ff);
               if (idx_plus == len_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_plus[ADDR_W-1:0];
                  rd_en  = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         start_symbol_ff <= fpr_pkg::START_SYMBOL_RST;
         hdr_bytes_ff    <= fpr_pkg::HDR_BYTES_RST;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         start_symbol_ff <= start_symbol_in;
         hdr_bytes_ff    <= hdr_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      len_ff          <= len_in;
      finished_ff     <= finished_in;
      packet_valid_ff <= packet_valid_in;
      error_ff        <= error_in;
      out_hdr_ff      <= out_hdr_in;
      payload_byte_ff <= payload_byte_in;
      byte_index_ff   <= byte_index_in;
      last_ff         <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_finished       = finished_ff;
   assign rsp_packet_valid   = packet_valid_ff;
   assign rsp_error          = error_ff;
   assign rsp_destination    = out_hdr_ff.destination;
   assign rsp_source         = out_hdr_ff.source;
   assign rsp_packet_id      = out_hdr_ff.packet_id;
   assign rsp_service        = out_hdr_ff.service;
   assign rsp_crc_byte       = out_hdr_ff.crc_byte;
   assign rsp_payload_length = out_hdr_ff.length;
   assign rsp_payload_byte   = payload_byte_ff;
   assign rsp_byte_index     = byte_index_ff;
   assign rsp_last           = last_ff;

   // no request is taken while a payload run is being emitted
   a_emit_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> req_stall)
      else $error("request accepted during payload run");

   // a held non-final packet result implies the run is still going
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_valid && !rsp_last |-> state_ff == ST_EMIT)
      else $error("payload run ended without a last result");

   // a take leaves the receiver rearmed
   a_take_rearms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_valid |-> !rsp_finished)
      else $error("finished still set on a taken packet");

   // a bad length byte drops the packet
   a_error_drops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_finished && !rsp_packet_valid)
      else $error("error result with packet state");

endmodule
